/* src/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the decimal text converter
// Holds the BCD conversion word, the request passed to the character
// emitter and the shift-and-add-3 step used by the conversion stages.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int MAG_W           = 32;
	localparam int NUM_DIGITS      = 10;
	localparam int BCD_W           = 4 * NUM_DIGITS;
	localparam int LEN_W           = 4;
	localparam int CHAR_W          = 8;
	localparam int STEPS_PER_STAGE = 8;
	localparam int NUM_DD_STAGES   = MAG_W / STEPS_PER_STAGE;
	localparam int SHAMT_W         = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
	localparam logic [LEN_W-1:0]  MAX_CHARS   = 4'd11;

	// Word carried through the double-dabble stages.
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} dd_word_t;

	// Request handed to the character emitter.
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
		logic [LEN_W-1:0] ndig;
		logic [LEN_W-1:0] total;
	} emit_req_t;

	// One double-dabble step: correct each BCD digit, then shift in one bit.
	function automatic dd_word_t dd_step(dd_word_t w);
		dd_word_t         r;
		logic [BCD_W-1:0] adj;
		adj = w.bcd;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (adj[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
			end
		end
		r.neg = w.neg;
		r.bcd = {adj[BCD_W-2:0], w.bin[MAG_W-1]};
		r.bin = {w.bin[MAG_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

/* src/itoa_dd.sv */
// ----------------------------------------------------------------------------
// itoa_dd: one pipeline stage of the binary to BCD conversion
// Applies a fixed number of double-dabble steps and registers the word,
// holding it while the next stage is full.
// ----------------------------------------------------------------------------
module itoa_dd
	import itoa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dd_word_t in_word,
	output logic     in_ready,
	output logic     out_valid,
	output dd_word_t out_word,
	input  logic     out_ready
);

	logic     valid_q;
	dd_word_t word_q;
	dd_word_t word_next;

	// Chain of conversion steps for this stage.
	always_comb begin
		word_next = in_word;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			word_next = dd_step(word_next);
		end
	end

	// The stage takes a new word when empty or when its word moves on.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_next;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

/* src/itoa_emit.sv */
// ----------------------------------------------------------------------------
// itoa_emit: character serializer
// Loads one converted value and sends its sign and digits, most
// significant first, one registered character per cycle.
// ----------------------------------------------------------------------------
module itoa_emit
	import itoa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  emit_req_t         req,
	output logic              req_ready,
	output logic              strobe,
	output logic [CHAR_W-1:0] character,
	output logic              is_last,
	output logic [LEN_W-1:0]  total_length
);

	logic              act_q;
	logic              sign_pend_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  total_q;
	logic              strobe_q;
	logic [CHAR_W-1:0] character_q;
	logic              is_last_q;
	logic [LEN_W-1:0]  total_length_q;
	logic              last_now;
	logic              load;
	logic [SHAMT_W-1:0] shamt;

	// The final digit of the current value frees the emitter for the next one.
	assign last_now  = act_q && !sign_pend_q && (cnt_q == 4'd1);
	assign req_ready = !act_q || last_now;
	assign load      = req_valid && req_ready;

	// Left-align the digits so the leading one sits in the top nibble.
	assign shamt = SHAMT_W'((NUM_DIGITS - int'(req.ndig)) * 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (load) begin
				act_q <= 1'b1;
			end else if (last_now) begin
				act_q <= 1'b0;
			end
		end
	end

	// Sequencing of the sign and digits, and the registered result.
	always_ff @(posedge clk) begin
		if (act_q) begin
			total_length_q <= total_q;
			if (sign_pend_q) begin
				character_q <= ASCII_MINUS;
				is_last_q   <= 1'b0;
			end else begin
				character_q <= ASCII_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
				is_last_q   <= (cnt_q == 4'd1);
			end
		end
		if (load) begin
			sign_pend_q <= req.neg;
			bcd_q       <= req.bcd << shamt;
			cnt_q       <= req.ndig;
			total_q     <= req.total;
		end else if (act_q) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	assign strobe       = strobe_q;
	assign character    = character_q;
	assign is_last      = is_last_q;
	assign total_length = total_length_q;

	// A digit is emitted only while digits remain.
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && !sign_pend_q |-> cnt_q != 4'd0)
		else $error("emitter active with no digits left");

	// The sign is never the last character.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && character == ASCII_MINUS |-> !is_last)
		else $error("sign flagged as last character");

	// A reported length stays within the text format.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> total_length != 4'd0 && total_length <= MAX_CHARS)
		else $error("character count out of range");

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Forms the magnitude, converts it to BCD in four pipelined double-dabble
// stages, counts the digits, and streams the characters out one a cycle.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// request   start / busy       value
// result    strobe (1 cycle)   character, is_last, total_length
//
// A value passes six pipeline registers (magnitude, four conversion stages,
// digit count), then the serializer load and its output register, before its
// first character is on the result port. The serializer sets the sustained
// rate, as it takes the next value when the last digit of the current one
// goes out; the pipeline fills behind it and busy rises when stage one holds.
// Reset clears all valid bits and the serializer; no clearing pass follows.
// The result port has no back-pressure; each character is shown for one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
	import itoa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [MAG_W-1:0]  value,
	output logic              strobe,
	output logic [CHAR_W-1:0] character,
	output logic              is_last,
	output logic [LEN_W-1:0]  total_length
);

	logic             valid_s1;
	dd_word_t         word_s1;
	logic             ready_s1;
	logic             accept;

	logic     dd_valid [NUM_DD_STAGES+1];
	dd_word_t dd_word  [NUM_DD_STAGES+1];
	logic     dd_ready [NUM_DD_STAGES+1];

	logic             valid_s6;
	emit_req_t        req_s6;
	logic             ready_s6;
	logic             emit_ready;
	logic [LEN_W-1:0] ndig;

	// Stage one: sign and magnitude; the most negative value wraps to itself.
	assign ready_s1 = !valid_s1 || dd_ready[0];
	assign busy     = !ready_s1;
	assign accept   = start && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.neg <= value[MAG_W-1];
			word_s1.bin <= value[MAG_W-1] ? (~value + 32'd1) : value;
			word_s1.bcd <= '0;
		end
	end

	assign dd_valid[0] = valid_s1;
	assign dd_word[0]  = word_s1;

	// Conversion stages.
	for (genvar g = 0; g < NUM_DD_STAGES; g++) begin : g_dd
		itoa_dd u_dd (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dd_valid[g]),
			.in_word   (dd_word[g]),
			.in_ready  (dd_ready[g]),
			.out_valid (dd_valid[g+1]),
			.out_word  (dd_word[g+1]),
			.out_ready (dd_ready[g+1])
		);
	end

	// Digit count: position of the highest nonzero digit, at least one.
	always_comb begin
		ndig = 4'd1;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (dd_word[NUM_DD_STAGES].bcd[4*d +: 4] != 4'd0) begin
				ndig = LEN_W'(d + 1);
			end
		end
	end

	assign ready_s6                = !valid_s6 || emit_ready;
	assign dd_ready[NUM_DD_STAGES] = ready_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (ready_s6) begin
			valid_s6 <= dd_valid[NUM_DD_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6 && dd_valid[NUM_DD_STAGES]) begin
			req_s6.neg   <= dd_word[NUM_DD_STAGES].neg;
			req_s6.bcd   <= dd_word[NUM_DD_STAGES].bcd;
			req_s6.ndig  <= ndig;
			req_s6.total <= ndig + {3'd0, dd_word[NUM_DD_STAGES].neg};
		end
	end

	// Character serializer.
	itoa_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (valid_s6),
		.req          (req_s6),
		.req_ready    (emit_ready),
		.strobe       (strobe),
		.character    (character),
		.is_last      (is_last),
		.total_length (total_length)
	);

	// Busy only while stage one holds a request that cannot move.
	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1)
		else $error("busy without a held request");

	// An accepted request occupies stage one on the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost at stage one");

	// A stalled count stage keeps its request.
	a_s6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !emit_ready |=> valid_s6 && $stable(req_s6))
		else $error("count stage request changed while stalled");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for signed_int_to_decimal_ascii
// Sends signed 32-bit values as start/busy requests and checks every
// character strobe against a decimal text predictor kept in the bench.
// A short table of directed values comes first, then random values in
// phases with and without sender idling.
// ----------------------------------------------------------------------------
module tb_top;
	import itoa_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 6;
	localparam int DRAIN_CYC   = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;
	localparam int PRINT_CAP   = 50;

	typedef logic [CHAR_W-1:0] text_t[$];

	// One expected character with its framing fields.
	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [LEN_W-1:0]  len;
	} char_rec_t;

	// Directed request; an empty text means the predictor supplies the answer.
	typedef struct {
		logic [MAG_W-1:0] val;
		string            text;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [MAG_W-1:0]  value;
	logic              strobe;
	logic [CHAR_W-1:0] character;
	logic              is_last;
	logic [LEN_W-1:0]  total_length;

	char_rec_t pending_chars[$];
	int        mismatch_count = 0;
	int        cycle_count    = 0;

	stim_row_t directed_rows[] = '{
		'{32'd0,          "0"},
		'{32'h7FFF_FFFF,  "2147483647"},
		'{32'h8000_0000,  "-2147483648"},
		'{32'd1,          "1"},
		'{32'hFFFF_FFFF,  "-1"},
		'{32'd9,          ""},
		'{32'd10,         ""},
		'{-32'sd9,        ""},
		'{-32'sd10,       ""},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'd12345,      ""},
		'{-32'sd67890,    ""},
		'{32'd999999999,  ""},
		'{32'd1000000000, ""},
		'{-32'sd999999999, ""},
		'{-32'sd1000000000, ""},
		'{32'h7FFF_FFFE,  ""},
		'{32'h8000_0001,  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd7,          ""},
		'{32'd0,          "0"}
	};

	signed_int_to_decimal_ascii dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.strobe       (strobe),
		.character    (character),
		.is_last      (is_last),
		.total_length (total_length)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Prints one mismatch line (up to a cap) and counts it.
	task automatic flag_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Decimal text of a two's complement value, most significant character first.
	function automatic void render_decimal(input logic [MAG_W-1:0] v, output text_t t);
		logic             neg;
		logic [MAG_W-1:0] mag;
		t = {};
		neg = v[MAG_W-1];
		// The negation wraps to itself for the most negative value, which is
		// exactly its magnitude when read as unsigned.
		mag = neg ? (~v + 1'b1) : v;
		do begin
			t.push_front(ASCII_ZERO + CHAR_W'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg) begin
			t.push_front(ASCII_MINUS);
		end
	endfunction

	// Queues one expected result per character of the text.
	function automatic void expect_text(input text_t t);
		char_rec_t r;
		for (int i = 0; i < t.size(); i++) begin
			r.ch   = t[i];
			r.last = (i == t.size() - 1);
			r.len  = LEN_W'(t.size());
			pending_chars.push_back(r);
		end
	endfunction

	// Random value: full range, a random digit count, near a power of ten, or just below 2^31 in magnitude.
	function automatic logic [MAG_W-1:0] random_value();
		longint lim;
		longint mag;
		int     k;
		mag = 0;
		case ($urandom_range(3))
			0: begin
				return $urandom;
			end
			1: begin
				k = $urandom_range(1, 10);
				lim = 1;
				for (int i = 0; i < k; i++) begin
					lim = lim * 10;
				end
				if (lim > 64'sd2147483648) begin
					lim = 64'sd2147483648;
				end
				mag = longint'($urandom) % lim;
			end
			2: begin
				k = $urandom_range(0, 9);
				mag = 1;
				for (int i = 0; i < k; i++) begin
					mag = mag * 10;
				end
				mag = mag + $urandom_range(2) - 1;
			end
			default: begin
				mag = 64'sd2147483648 - $urandom_range(3);
			end
		endcase
		if ($urandom_range(1)) begin
			mag = -mag;
		end
		return MAG_W'(mag);
	endfunction

	// Holds one request until the block takes it, then queues its characters.
	// Start is left high, so back-to-back requests keep it asserted without a gap.
	task automatic send_value(input logic [MAG_W-1:0] v, input string text);
		text_t t;
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (text.len() == 0) begin
			render_decimal(v, t);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				t.push_back(text[i]);
			end
		end
		expect_text(t);
	endtask

	// Sender idles for a random stretch with the given probability in percent.
	task automatic maybe_idle(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			value <= $urandom;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Sender holds off until every queued character has come out.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Result checker: every strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		char_rec_t r;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected character 0x%02h", character));
			end else begin
				r = pending_chars.pop_front();
				if (character !== r.ch) begin
					flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
						character, r.ch));
				end
				if (is_last !== r.last) begin
					flag_mismatch($sformatf("is_last %b, expected %b", is_last, r.last));
				end
				if (total_length !== r.len) begin
					flag_mismatch($sformatf("total_length %0d, expected %0d",
						total_length, r.len));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus and end of test.
	initial begin
		int idle_pct[3];
		idle_pct = '{0, 74, 30};
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed values back to back.
		foreach (directed_rows[i]) begin
			send_value(directed_rows[i].val, directed_rows[i].text);
		end

		// Random phases; each one begins after the block has fully drained.
		foreach (idle_pct[p]) begin
			wait_drained();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_value(random_value(), "");
				maybe_idle(idle_pct[p]);
			end
		end

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (pending_chars.size() != 0) begin
			flag_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
		end
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
